FILE: design/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared sizes, payload types, codes and the per-cell control struct.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_W     = 32;
  localparam int PRIO_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic        [PRIO_W-1:0]  prio_t;
  typedef logic        [COUNT_W-1:0] count_t;
  typedef logic        [CNT_W-1:0]   occ_t;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Broadcast to every cell for one request.
  typedef struct packed {
    logic   enq;
    logic   deq;
    value_t value;
    prio_t  prio;
  } cell_ctrl_t;

endpackage

FILE: design/spq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface spq_in_if;
  import spq_pkg::*;

  logic   valid;
  logic   ready;
  kind_t  kind;
  value_t item_value;
  prio_t  item_priority;

  modport source (output valid, kind, item_value, item_priority, input ready);
  modport sink   (input valid, kind, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic    valid;
  logic    ready;
  value_t  out_value;
  status_t status;
  count_t  entry_count;

  modport source (output valid, out_value, status, entry_count, input ready);
  modport sink   (input valid, out_value, status, entry_count, output ready);
endinterface

FILE: design/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue cell
// Holds one entry; keeps it, takes the new entry, or takes a neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                prev_keep,
  input  spq_pkg::value_t     prev_value,
  input  spq_pkg::prio_t      prev_prio,
  input  spq_pkg::value_t     next_value,
  input  spq_pkg::prio_t      next_prio,
  output logic                keep,
  output spq_pkg::value_t     value,
  output spq_pkg::prio_t      prio
);
  import spq_pkg::*;

  value_t value_r, value_nxt;
  prio_t  prio_r,  prio_nxt;

  // An entry stays put when it ranks at or above the new one.
  assign keep = occupied && (prio_r >= ctrl.prio);

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (ctrl.enq && !keep) begin
      if (prev_keep) begin
        value_nxt = ctrl.value;
        prio_nxt  = ctrl.prio;
      end else begin
        value_nxt = prev_value;
        prio_nxt  = prev_prio;
      end
    end else if (ctrl.deq) begin
      value_nxt = next_value;
      prio_nxt  = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign value = value_r;
  assign prio  = prio_r;
endmodule

FILE: design/stable_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue core
// A result appears in the output register the cycle after its request is
// accepted. One request per cycle is accepted, as the whole cell row
// updates at once, as long as the result side keeps taking.
// Reset (synchronous, active low) empties the queue and the output register;
// cell contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module stable_priority_queue_core (
  input  logic             clk,
  input  logic             rst_n,
  spq_in_if.sink           in_chan,
  spq_out_if.source        out_chan
);
  import spq_pkg::*;

  // The queue is a row of cells sorted head first, priorities never
  // increasing toward the tail. On an enqueue every occupied cell compares
  // its priority to the new one at once; the cells that rank lower move one
  // place toward the tail and the first of them takes the new entry, which
  // lands behind all entries of equal priority. On a dequeue every cell
  // takes its tail-side neighbor's contents.

  occ_t    count_r, count_nxt;
  logic    out_valid_r;
  value_t  out_value_r;
  status_t out_status_r;
  count_t  out_count_r;

  logic       accept;
  logic       is_full, is_empty;
  cell_ctrl_t ctrl;

  value_t cell_value [QUEUE_DEPTH];
  prio_t  cell_prio  [QUEUE_DEPTH];
  logic   cell_keep  [QUEUE_DEPTH];

  // The output register frees itself when the consumer takes the result.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign is_full  = (count_r == occ_t'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    ctrl.enq   = accept && (in_chan.kind == KIND_ENQ) && !is_full;
    ctrl.deq   = accept && (in_chan.kind == KIND_DEQ) && !is_empty;
    ctrl.value = in_chan.item_value;
    ctrl.prio  = in_chan.item_priority;
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic   prev_keep;
      value_t prev_value, next_value;
      prio_t  prev_prio,  next_prio;

      if (i == 0) begin : g_head
        // Nothing stands ahead of the head, so it takes a new entry directly.
        assign prev_keep  = 1'b1;
        assign prev_value = '0;
        assign prev_prio  = '0;
      end else begin : g_body
        assign prev_keep  = cell_keep[i-1];
        assign prev_value = cell_value[i-1];
        assign prev_prio  = cell_prio[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign next_value = '0;
        assign next_prio  = '0;
      end else begin : g_inner
        assign next_value = cell_value[i+1];
        assign next_prio  = cell_prio[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ_t'(i) < count_r),
        .prev_keep  (prev_keep),
        .prev_value (prev_value),
        .prev_prio  (prev_prio),
        .next_value (next_value),
        .next_prio  (next_prio),
        .keep       (cell_keep[i]),
        .value      (cell_value[i]),
        .prio       (cell_prio[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctrl.enq) begin
      count_nxt = count_r + occ_t'(1);
    end else if (ctrl.deq) begin
      count_nxt = count_r - occ_t'(1);
    end
  end

  // Count and output valid are control state; the result payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= ctrl.deq ? cell_value[0] : '0;
      out_count_r  <= count_t'(count_nxt);
      if (in_chan.kind == KIND_ENQ) begin
        out_status_r <= is_full ? ST_FULL : ST_OK;
      end else begin
        out_status_r <= is_empty ? ST_EMPTY : ST_OK;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_value   = out_value_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.entry_count = out_count_r;
endmodule
